// File: hdl/assert_macros.svh
// Assertion macros shared by the orbit generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("orbit generator: implication check failed");

// Next-cycle implication.
`define SA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("orbit generator: next-cycle check failed");

`endif

// File: hdl/sa_pkg.sv
// ---------------------------------------------------------------------------
// sa_pkg
// Types, constants and fixed-point helpers for the orbit pixel generator.
// ---------------------------------------------------------------------------
package sa_pkg;

	localparam int FRAC_BITS = 29;

	localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
	localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
	localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
	localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
	localparam logic signed [33:0] ONE_Q29     = 34'sd536870912;
	localparam logic [16:0]        COUNT_MAX   = 17'h1FFFF;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_XX,
		ST_MUL_YY,
		ST_MUL_XY,
		ST_ARG,
		ST_ROT,
		ST_PIX_X,
		ST_PIX_Y,
		ST_FIN
	} state_t;

	typedef enum logic [2:0] {
		REG_PARAM_A   = 3'd0,
		REG_PARAM_B   = 3'd1,
		REG_X_EDGE    = 3'd2,
		REG_Y_EDGE    = 3'd3,
		REG_X_SCALE   = 3'd4,
		REG_Y_SCALE   = 3'd5,
		REG_WARMUP    = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic                load;
		logic signed [33:0]  arg;
	} cordic_ctrl_t;

	typedef struct packed {
		logic                busy;
		logic                neg;
		logic signed [33:0]  vx;
		logic signed [33:0]  vy;
	} cordic_stat_t;

	typedef struct packed {
		logic signed [33:0] z;
		logic               neg;
	} reduced_t;

	function automatic logic signed [33:0] atan_q29(input logic [4:0] idx);
		logic signed [33:0] r;
		unique case (idx)
			5'd0:  r = 34'sd421657428;
			5'd1:  r = 34'sd248918915;
			5'd2:  r = 34'sd131521918;
			5'd3:  r = 34'sd66762579;
			5'd4:  r = 34'sd33510843;
			5'd5:  r = 34'sd16771758;
			5'd6:  r = 34'sd8387925;
			5'd7:  r = 34'sd4194219;
			5'd8:  r = 34'sd2097141;
			5'd9:  r = 34'sd1048575;
			5'd10: r = 34'sd524288;
			5'd11: r = 34'sd262144;
			5'd12: r = 34'sd131072;
			5'd13: r = 34'sd65536;
			5'd14: r = 34'sd32768;
			5'd15: r = 34'sd16384;
			5'd16: r = 34'sd8192;
			5'd17: r = 34'sd4096;
			5'd18: r = 34'sd2048;
			5'd19: r = 34'sd1024;
			5'd20: r = 34'sd512;
			5'd21: r = 34'sd256;
			5'd22: r = 34'sd128;
			5'd23: r = 34'sd64;
			5'd24: r = 34'sd32;
			5'd25: r = 34'sd16;
			5'd26: r = 34'sd8;
			5'd27: r = 34'sd4;
			5'd28: r = 34'sd2;
			5'd29: r = 34'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// The argument is always smaller than 2*pi in magnitude, so one wrap
	// brings it into [-pi, pi]; the fold by pi then reaches [-pi/2, pi/2].
	function automatic reduced_t reduce_arg(input logic signed [33:0] arg);
		reduced_t r;
		r.z   = arg;
		r.neg = 1'b0;
		if (r.z > PI_Q29) begin
			r.z = r.z - TWO_PI_Q29;
		end else if (r.z < -PI_Q29) begin
			r.z = r.z + TWO_PI_Q29;
		end
		if (r.z > HALF_PI_Q29) begin
			r.z   = r.z - PI_Q29;
			r.neg = 1'b1;
		end else if (r.z < -HALF_PI_Q29) begin
			r.z   = r.z + PI_Q29;
			r.neg = 1'b1;
		end
		return r;
	endfunction

	// Round half up from Q30 to Q29, apply the fold sign and clamp to [-1, 1].
	function automatic logic signed [30:0] to_frac(input logic signed [33:0] q30,
			input logic neg);
		logic signed [33:0] r;
		r = (q30 + 34'sd1) >>> 1;
		if (neg) begin
			r = -r;
		end
		if (r > ONE_Q29) begin
			r = ONE_Q29;
		end
		if (r < -ONE_Q29) begin
			r = -ONE_Q29;
		end
		return r[30:0];
	endfunction

endpackage

// File: hdl/sa_cordic.sv
// ---------------------------------------------------------------------------
// sa_cordic
// Rotation-mode CORDIC, one round per cycle, sine in vy and cosine in vx.
// ---------------------------------------------------------------------------
module sa_cordic #(
	parameter int CORDIC_ROUNDS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sa_pkg::cordic_ctrl_t ctrl,
	output sa_pkg::cordic_stat_t stat
);

	localparam int RW = (CORDIC_ROUNDS > 1) ? $clog2(CORDIC_ROUNDS) : 1;
	localparam logic [RW-1:0] LAST = RW'(CORDIC_ROUNDS - 1);

	logic              busy_q;
	logic [RW-1:0]     round_q;
	logic signed [33:0] vx_q, vy_q, z_q;
	logic              neg_q;
	sa_pkg::reduced_t  red;
	logic signed [33:0] dx, dy, ang;

	assign red = sa_pkg::reduce_arg(ctrl.arg);
	assign dx  = vy_q >>> round_q;
	assign dy  = vx_q >>> round_q;
	assign ang = sa_pkg::atan_q29(5'(round_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			round_q <= '0;
		end else if (ctrl.load) begin
			busy_q  <= 1'b1;
			round_q <= '0;
		end else if (busy_q) begin
			if (round_q == LAST) begin
				busy_q <= 1'b0;
			end
			round_q <= round_q + RW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			vx_q  <= sa_pkg::GAIN_Q30;
			vy_q  <= '0;
			z_q   <= red.z;
			neg_q <= red.neg;
		end else if (busy_q) begin
			if (z_q >= 0) begin
				vx_q <= vx_q - dx;
				vy_q <= vy_q + dy;
				z_q  <= z_q - ang;
			end else begin
				vx_q <= vx_q + dx;
				vy_q <= vy_q - dy;
				z_q  <= z_q + ang;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.neg  = neg_q;
	assign stat.vx   = vx_q;
	assign stat.vy   = vy_q;

endmodule

// File: hdl/trig_attractor_orbit_pixel_gen.sv
// ---------------------------------------------------------------------------
// trig_attractor_orbit_pixel_gen
// Steps the orbit x' = sin(x*x - y*y + a), y' = cos(2xy + b) and maps each
// new point to a pixel on the canvas.
// ---------------------------------------------------------------------------
// Usage: each item taken on the input channel (in_valid high, in_stall low)
// advances the orbit by one point; restart set in the item zeroes the orbit
// and the step count first. Exactly one result item follows on the output
// channel with the pixel, the canvas and hit flags and the new point.
// Each item runs through the single CORDIC unit, once for the sine and
// once for the cosine, one round a cycle, and makes five passes through
// one shared 33 by 33 multiplier. in_stall stays high while an item is
// in work. A finished result sits in the output register; if the
// receiver stalls, the next item still runs and waits only in its final
// state until the register frees. Configuration writes are taken at any
// time through cfg_we, cfg_index and cfg_data and belong between items.
// Reset clears the orbit, the count and both channels and loads the
// register defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module trig_attractor_orbit_pixel_gen #(
	parameter int CANVAS_SIZE   = 256,
	parameter int CORDIC_ROUNDS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         pixel_col,
	output logic [7:0]         pixel_row,
	output logic               on_canvas,
	output logic               hit_valid,
	output logic signed [30:0] x_value,
	output logic signed [30:0] y_value
);

	sa_pkg::state_t state_q, state_d;

	logic signed [31:0] param_a_q, param_b_q, x_edge_q, y_edge_q;
	logic [15:0]        x_scale_q, y_scale_q, warmup_q;

	logic signed [30:0] x_q, y_q, nx_q, ny_q;
	logic [16:0]        count_q;
	logic               pass_q;
	logic signed [65:0] prod_q, acc_q;
	logic signed [13:0] col_q;
	logic signed [32:0] mul_a, mul_b;

	sa_pkg::cordic_ctrl_t cctrl;
	sa_pkg::cordic_stat_t cstat;

	logic               accept, fin_go;
	logic signed [33:0] arg_x, arg_y;
	logic signed [13:0] row_raw;
	logic               col_on, row_on, on_now;

	assign in_stall = (state_q != sa_pkg::ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign fin_go   = (state_q == sa_pkg::ST_FIN) && (!out_valid || !out_stall);

	assign arg_x = $signed(acc_q[62:29]) + {{2{param_a_q[31]}}, param_a_q};
	assign arg_y = $signed(prod_q[61:28]) + {{2{param_b_q[31]}}, param_b_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			param_a_q <= 32'sd205143744;
			param_b_q <= -32'sd543630117;
			x_edge_q  <= -32'sd322122547;
			y_edge_q  <= -32'sd134217728;
			x_scale_q <= 16'd54613;
			y_scale_q <= 16'd52429;
			warmup_q  <= 16'd1000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sa_pkg::REG_PARAM_A: param_a_q <= cfg_data;
				sa_pkg::REG_PARAM_B: param_b_q <= cfg_data;
				sa_pkg::REG_X_EDGE:  x_edge_q  <= cfg_data;
				sa_pkg::REG_Y_EDGE:  y_edge_q  <= cfg_data;
				sa_pkg::REG_X_SCALE: x_scale_q <= cfg_data[15:0];
				sa_pkg::REG_Y_SCALE: y_scale_q <= cfg_data[15:0];
				sa_pkg::REG_WARMUP:  warmup_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cctrl.load = 1'b0;
		cctrl.arg  = arg_x;
		mul_a      = '0;
		mul_b      = '0;
		unique case (state_q)
			sa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = sa_pkg::ST_MUL_XX;
				end
			end
			sa_pkg::ST_MUL_XX: begin
				mul_a   = {{2{x_q[30]}}, x_q};
				mul_b   = {{2{x_q[30]}}, x_q};
				state_d = sa_pkg::ST_MUL_YY;
			end
			sa_pkg::ST_MUL_YY: begin
				mul_a   = {{2{y_q[30]}}, y_q};
				mul_b   = {{2{y_q[30]}}, y_q};
				state_d = sa_pkg::ST_MUL_XY;
			end
			sa_pkg::ST_MUL_XY: begin
				mul_a   = {{2{x_q[30]}}, x_q};
				mul_b   = {{2{y_q[30]}}, y_q};
				state_d = sa_pkg::ST_ARG;
			end
			sa_pkg::ST_ARG: begin
				cctrl.load = 1'b1;
				state_d    = sa_pkg::ST_ROT;
			end
			sa_pkg::ST_ROT: begin
				// After the sine pass the same unit is reloaded for the cosine.
				if (!cstat.busy && !pass_q) begin
					cctrl.load = 1'b1;
					cctrl.arg  = arg_y;
				end else if (!cstat.busy) begin
					state_d = sa_pkg::ST_PIX_X;
				end
			end
			sa_pkg::ST_PIX_X: begin
				mul_a   = {{2{nx_q[30]}}, nx_q} - {x_edge_q[31], x_edge_q};
				mul_b   = {17'd0, x_scale_q};
				state_d = sa_pkg::ST_PIX_Y;
			end
			sa_pkg::ST_PIX_Y: begin
				mul_a   = {{2{ny_q[30]}}, ny_q} - {y_edge_q[31], y_edge_q};
				mul_b   = {17'd0, y_scale_q};
				state_d = sa_pkg::ST_FIN;
			end
			sa_pkg::ST_FIN: begin
				if (fin_go) begin
					state_d = sa_pkg::ST_IDLE;
				end
			end
			default: state_d = sa_pkg::ST_IDLE;
		endcase
	end

	sa_cordic #(
		.CORDIC_ROUNDS(CORDIC_ROUNDS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cctrl),
		.stat   (cstat)
	);

	// Shared multiplier and datapath registers
	always_ff @(posedge clk) begin
		// The cross product must survive the sine pass, and the row product
		// must survive a stalled finish, so the multiplier result is held then.
		if (state_q == sa_pkg::ST_ARG || state_q == sa_pkg::ST_ROT ||
				state_q == sa_pkg::ST_FIN) begin
			prod_q <= prod_q;
		end else begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == sa_pkg::ST_MUL_YY) begin
			acc_q <= prod_q;
		end
		if (state_q == sa_pkg::ST_MUL_XY) begin
			acc_q <= acc_q - prod_q;
		end
		if (state_q == sa_pkg::ST_ROT && !cstat.busy && !pass_q) begin
			nx_q <= sa_pkg::to_frac(cstat.vy, cstat.neg);
		end
		if (state_q == sa_pkg::ST_ROT && !cstat.busy && pass_q) begin
			ny_q <= sa_pkg::to_frac(cstat.vx, cstat.neg);
		end
		if (state_q == sa_pkg::ST_PIX_Y) begin
			col_q <= prod_q[50:37];
		end
	end

	assign row_raw = prod_q[50:37];
	assign col_on  = !col_q[13] && ({1'b0, col_q[12:0]} < 14'(CANVAS_SIZE));
	assign row_on  = !row_raw[13] && ({1'b0, row_raw[12:0]} < 14'(CANVAS_SIZE));
	assign on_now  = col_on && row_on;

	// Orbit state, pass flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			count_q   <= '0;
			pass_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept && restart) begin
				x_q     <= '0;
				y_q     <= '0;
				count_q <= '0;
			end
			if (state_q == sa_pkg::ST_ARG) begin
				pass_q <= 1'b0;
			end else if (state_q == sa_pkg::ST_ROT && !cstat.busy) begin
				pass_q <= 1'b1;
			end
			if (fin_go) begin
				out_valid <= 1'b1;
				x_q       <= nx_q;
				y_q       <= ny_q;
				if (count_q != sa_pkg::COUNT_MAX) begin
					count_q <= count_q + 17'd1;
				end
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			pixel_col <= on_now ? col_q[7:0] : 8'd0;
			pixel_row <= on_now ? row_raw[7:0] : 8'd0;
			on_canvas <= on_now;
			hit_valid <= on_now && (count_q > {1'b0, warmup_q});
			x_value   <= nx_q;
			y_value   <= ny_q;
		end
	end

	`SA_ASSERT_IMP(a_cordic_only_in_rot, clk, arst_n, cstat.busy, state_q == sa_pkg::ST_ROT)
	`SA_ASSERT_IMP(a_hit_needs_canvas, clk, arst_n, out_valid && hit_valid, on_canvas)
	`SA_ASSERT_IMP(a_off_canvas_zero, clk, arst_n, out_valid && !on_canvas,
		pixel_col == 8'd0 && pixel_row == 8'd0)
	`SA_ASSERT_NEXT(a_finish_raises_valid, clk, arst_n, fin_go, out_valid)

endmodule

// File: tb/orbit_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// orbit_checker
// Watches both channels and the register write port, keeps its own copy of
// the orbit and the registers, predicts every result and compares it.
// ---------------------------------------------------------------------------
module orbit_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               restart,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [7:0]         pixel_col,
	input  logic [7:0]         pixel_row,
	input  logic               on_canvas,
	input  logic               hit_valid,
	input  logic signed [30:0] x_value,
	input  logic signed [30:0] y_value,
	output int                 fail_count,
	output int                 pending,
	output int                 hits_seen,
	output int                 offs_seen
);

	typedef struct packed {
		logic [7:0]         col;
		logic [7:0]         row;
		logic               on;
		logic               hit;
		logic signed [30:0] xv;
		logic signed [30:0] yv;
	} pixel_item_t;

	pixel_item_t pixel_queue[$];

	logic signed [31:0] par_a, par_b, x_edge, y_edge;
	logic [15:0]        x_scale, y_scale, warmup;
	longint             cur_x, cur_y;
	int unsigned        steps;

	localparam longint PI_L   = 64'sd1686629713;
	localparam longint TWO_PI = 64'sd3373259426;
	localparam longint HALF_PI = 64'sd843314857;

	function automatic longint atan_entry(input int i);
		longint t[30] = '{421657428, 248918915, 131521918, 66762579, 33510843,
			16771758, 8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072,
			65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
			8, 4, 2, 1};
		return t[i];
	endfunction

	function automatic longint clamp_one(input longint q30, input bit flip);
		longint r;
		r = (q30 + 1) >>> 1;
		if (flip) r = -r;
		if (r > 64'sd536870912) r = 64'sd536870912;
		if (r < -64'sd536870912) r = -64'sd536870912;
		return r;
	endfunction

	// Returns sine in the first result and cosine in the second, Q29.
	task automatic rotate(input longint angle, output longint s, output longint c);
		longint z, vx, vy, dx, dy;
		bit     flip;
		z = angle % TWO_PI;
		vx = 64'sd652032874;
		vy = 0;
		flip = 0;
		if (z > PI_L) z -= TWO_PI;
		else if (z < -PI_L) z += TWO_PI;
		if (z > HALF_PI) begin
			z -= PI_L;
			flip = 1;
		end else if (z < -HALF_PI) begin
			z += PI_L;
			flip = 1;
		end
		for (int i = 0; i < 24; i++) begin
			dx = vy >>> i;
			dy = vx >>> i;
			if (z >= 0) begin
				vx -= dx;
				vy += dy;
				z -= atan_entry(i);
			end else begin
				vx += dx;
				vy -= dy;
				z += atan_entry(i);
			end
		end
		s = clamp_one(vy, flip);
		c = clamp_one(vx, flip);
	endtask

	task automatic predict_step(input logic rst_orbit);
		longint      nx, ny, dummy, col, row;
		pixel_item_t e;
		if (rst_orbit) begin
			cur_x = 0;
			cur_y = 0;
			steps = 0;
		end
		rotate(((cur_x * cur_x - cur_y * cur_y) >>> 29) + longint'(par_a), nx, dummy);
		rotate(((cur_x * cur_y) >>> 28) + longint'(par_b), dummy, ny);
		col = ((nx - longint'(x_edge)) * longint'({1'b0, x_scale})) >>> 37;
		row = ((ny - longint'(y_edge)) * longint'({1'b0, y_scale})) >>> 37;
		e.on = col >= 0 && col < 256 && row >= 0 && row < 256;
		e.hit = e.on && steps > warmup;
		e.col = e.on ? col[7:0] : 8'd0;
		e.row = e.on ? row[7:0] : 8'd0;
		e.xv = nx[30:0];
		e.yv = ny[30:0];
		if (steps < 131071) steps++;
		cur_x = nx;
		cur_y = ny;
		pixel_queue.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		pixel_item_t e;
		if (!arst_n) begin
			par_a <= 32'sd205143744;
			par_b <= -32'sd543630117;
			x_edge <= -32'sd322122547;
			y_edge <= -32'sd134217728;
			x_scale <= 16'd54613;
			y_scale <= 16'd52429;
			warmup <= 16'd1000;
			cur_x = 0;
			cur_y = 0;
			steps = 0;
			fail_count <= 0;
			hits_seen <= 0;
			offs_seen <= 0;
			pixel_queue.delete();
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pixel_queue.size() == 0) begin
					fail_count <= fail_count + 1;
					$display("%0t: result with nothing expected: col %0d row %0d", $time,
						pixel_col, pixel_row);
				end else begin
					e = pixel_queue.pop_front();
					if (e !== {pixel_col, pixel_row, on_canvas, hit_valid, x_value,
							y_value}) begin
						fail_count <= fail_count + 1;
						$display("%0t: expected col %0d row %0d on %b hit %b x %0d y %0d",
							$time, e.col, e.row, e.on, e.hit, e.xv, e.yv);
						$display("%0t: actual   col %0d row %0d on %b hit %b x %0d y %0d",
							$time, pixel_col, pixel_row, on_canvas, hit_valid, x_value,
							y_value);
					end
					if (e.hit) hits_seen <= hits_seen + 1;
					if (!e.on) offs_seen <= offs_seen + 1;
				end
			end
			// The step uses the registers as they stood before any write at this edge.
			if (in_valid && !in_stall) predict_step(restart);
			if (cfg_we) begin
				case (cfg_index)
					sa_pkg::REG_PARAM_A: par_a <= cfg_data;
					sa_pkg::REG_PARAM_B: par_b <= cfg_data;
					sa_pkg::REG_X_EDGE:  x_edge <= cfg_data;
					sa_pkg::REG_Y_EDGE:  y_edge <= cfg_data;
					sa_pkg::REG_X_SCALE: x_scale <= cfg_data[15:0];
					sa_pkg::REG_Y_SCALE: y_scale <= cfg_data[15:0];
					sa_pkg::REG_WARMUP:  warmup <= cfg_data[15:0];
					default: ;
				endcase
			end
			pending <= pixel_queue.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Drives orbit steps (some with restart) and register settings into the orbit generator under
// random gaps and stalls; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top;

	logic               clk, arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid, in_stall, restart;
	logic               out_valid, out_stall;
	logic [7:0]         pixel_col, pixel_row;
	logic               on_canvas, hit_valid;
	logic signed [30:0] x_value, y_value;
	int                 fail_count, pending, hits_seen, offs_seen;
	int                 gap_pct, stall_pct;
	int                 steps_sent;

	trig_attractor_orbit_pixel_gen dut (.*);

	orbit_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

	task automatic write_reg(input sa_pkg::cfg_reg_t idx, input logic [31:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// Waits until every expected result has come, then lets the block settle.
	task automatic drain;
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	task automatic send_step(input logic rs);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < gap_pct) @(posedge clk);
		end
		in_valid <= 1;
		restart <= rs;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		steps_sent++;
	endtask

	task automatic run_phase(input int n, input int gp, input int sp);
		gap_pct = gp;
		stall_pct = sp;
		for (int i = 0; i < n; i++) send_step($urandom_range(39) == 0);
		drain();
	endtask

	initial begin
		cfg_we = 0;
		cfg_index = sa_pkg::REG_PARAM_A;
		cfg_data = 0;
		in_valid = 0;
		restart = 0;
		out_stall = 0;
		gap_pct = 0;
		stall_pct = 0;
		steps_sent = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: defaults, restart, then extremes of every register.
		send_step(1);
		send_step(0);
		send_step(1);
		drain();
		write_reg(sa_pkg::REG_PARAM_A, 32'h7FFF_FFFF);
		write_reg(sa_pkg::REG_PARAM_B, 32'h8000_0000);
		write_reg(sa_pkg::REG_X_EDGE, 32'h8000_0000);
		write_reg(sa_pkg::REG_Y_EDGE, 32'h7FFF_FFFF);
		write_reg(sa_pkg::REG_X_SCALE, 32'h0000_FFFF);
		write_reg(sa_pkg::REG_Y_SCALE, 32'h0000_FFFF);
		write_reg(sa_pkg::REG_WARMUP, 32'h0000_0000);
		send_step(1);
		send_step(0);
		send_step(0);
		drain();
		// Tiny scale puts every point on pixel zero, so hits follow quickly.
		write_reg(sa_pkg::REG_X_EDGE, 32'h0000_0000);
		write_reg(sa_pkg::REG_Y_EDGE, 32'h8000_0000);
		write_reg(sa_pkg::REG_X_SCALE, 32'h0000_0000);
		write_reg(sa_pkg::REG_Y_SCALE, 32'h0000_0001);
		write_reg(sa_pkg::REG_PARAM_A, 32'h8000_0000);
		write_reg(sa_pkg::REG_PARAM_B, 32'h7FFF_FFFF);
		write_reg(sa_pkg::REG_WARMUP, 32'h0000_0002);
		for (int i = 0; i < 6; i++) send_step(i == 0);
		drain();
		write_reg(sa_pkg::REG_WARMUP, 32'h0000_FFFF);
		send_step(0);
		send_step(0);
		drain();

		// Random phases: two under the stock settings, six under random ones.
		for (int ph = 0; ph < 8; ph++) begin
			if (ph == 0 || ph == 4) begin
				write_reg(sa_pkg::REG_PARAM_A, 32'd205143744);
				write_reg(sa_pkg::REG_PARAM_B, -32'sd543630117);
				write_reg(sa_pkg::REG_X_EDGE, -32'sd322122547);
				write_reg(sa_pkg::REG_Y_EDGE, -32'sd134217728);
				write_reg(sa_pkg::REG_X_SCALE, 32'd54613);
				write_reg(sa_pkg::REG_Y_SCALE, 32'd52429);
				write_reg(sa_pkg::REG_WARMUP, $urandom_range(20));
			end else begin
				write_reg(sa_pkg::REG_PARAM_A, $urandom);
				write_reg(sa_pkg::REG_PARAM_B, $urandom);
				write_reg(sa_pkg::REG_X_EDGE, -$urandom_range(32'h3000_0000));
				write_reg(sa_pkg::REG_Y_EDGE, -$urandom_range(32'h3000_0000));
				write_reg(sa_pkg::REG_X_SCALE, $urandom);
				write_reg(sa_pkg::REG_Y_SCALE, $urandom);
				write_reg(sa_pkg::REG_WARMUP, $urandom_range(40));
			end
			case (ph % 4)
				0: run_phase(90, 0, 0);
				1: run_phase(90, 46, 0);
				2: run_phase(90, 0, 46);
				default: run_phase(90, 32, 32);
			endcase
		end

		$display("Sent %0d steps over eight register settings and edge cases;", steps_sent);
		$display("%0d hits flagged and %0d points off the canvas.", hits_seen, offs_seen);
		if (fail_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/sa_pkg.sv
hdl/sa_cordic.sv
hdl/trig_attractor_orbit_pixel_gen.sv
tb/orbit_checker.sv
tb/tb_top.sv
